@@ src/tof_modulation_weight_defines.svh @@
// ----------------------------------------------------------------------------
// tof_modulation_weight_defines
// Assertion macros for the modulation weight top level.
// ----------------------------------------------------------------------------
`ifndef TOF_MODULATION_WEIGHT_DEFINES_SVH
`define TOF_MODULATION_WEIGHT_DEFINES_SVH

// same-cycle implication, reset disables the check
`define TOFMW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TOFMW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tofmw_pkg.sv @@
// ----------------------------------------------------------------------------
// tofmw_pkg
// Types, register indexes and waveform codes of the modulation weight block.
// ----------------------------------------------------------------------------
package tofmw_pkg;

    localparam int DEF_COS_TABLE_DEPTH = 1024;
    localparam int DEF_PHASE_BITS      = 32;

    localparam int RATE_W = 48;
    localparam int DATA_W = 48;

    // register indexes
    typedef enum logic [2:0] {
        REG_ILLUM_RATE  = 3'd0,
        REG_BEAT_RATE   = 3'd1,
        REG_PATH_RATE   = 3'd2,
        REG_SNR_OFFSET  = 3'd3,
        REG_SNR_WAVE    = 3'd4,
        REG_ILL_WAVE    = 3'd5,
        REG_LOW_PASS    = 3'd6
    } reg_idx_t;

    // waveform codes
    localparam logic [2:0] WAVE_SINE = 3'd0;
    localparam logic [2:0] WAVE_RECT = 3'd1;
    localparam logic [2:0] WAVE_TRI  = 3'd2;
    localparam logic [2:0] WAVE_SAW  = 3'd3;
    localparam logic [2:0] WAVE_TRAP = 3'd4;

    typedef struct packed {
        logic [RATE_W-1:0] illum_rate;
        logic [RATE_W-1:0] beat_rate;
        logic [RATE_W-1:0] path_rate;
        logic [31:0]       snr_offset;
        logic [2:0]        snr_wave;
        logic [2:0]        ill_wave;
        logic              low_pass;
    } cfg_t;

    // phases leaving the phase stages
    typedef struct packed {
        logic        valid;
        logic [31:0] p_snr;
        logic [31:0] p_ill;
    } phase_bus_t;

    // waveform terms leaving the wave stages
    typedef struct packed {
        logic               valid;
        logic signed [18:0] ill_term;
        logic signed [17:0] snr_term;
        logic signed [17:0] lp_val;
        logic [48:0]        c2;
        logic [48:0]        c3;
    } wave_bus_t;

    // distance to the nearest whole turn, up to half a turn
    function automatic logic [31:0] fold(input logic [31:0] p);
        return p[31] ? (32'd0 - p) : p;
    endfunction

endpackage

@@ src/tofmw_phase.sv @@
// ----------------------------------------------------------------------------
// tofmw_phase
// Phase stages: split rate products, then modulo-one-turn phase sums.
// ----------------------------------------------------------------------------
module tofmw_phase #(
    parameter int PHASE_BITS = tofmw_pkg::DEF_PHASE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [31:0]           sample_time,
    input  logic [31:0]           path_dist,
    input  tofmw_pkg::cfg_t       cfg,
    output tofmw_pkg::phase_bus_t out_bus
);
    import tofmw_pkg::*;

    localparam int PAD = 32 - PHASE_BITS;

    // stage 1: partial products, low and high parts of each rate
    logic        v1_reg;
    logic [63:0] ill_lo_reg, beat_lo_reg, path_lo_reg;
    logic [15:0] ill_hi_reg, beat_hi_reg, path_hi_reg;
    logic [47:0] ill_hi_full, beat_hi_full, path_hi_full;

    assign ill_hi_full  = cfg.illum_rate[47:32] * sample_time;
    assign beat_hi_full = cfg.beat_rate[47:32] * sample_time;
    assign path_hi_full = cfg.path_rate[47:32] * path_dist;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ill_lo_reg  <= cfg.illum_rate[31:0] * sample_time;
        beat_lo_reg <= cfg.beat_rate[31:0] * sample_time;
        path_lo_reg <= cfg.path_rate[31:0] * path_dist;
        ill_hi_reg  <= ill_hi_full[15:0];
        beat_hi_reg <= beat_hi_full[15:0];
        path_hi_reg <= path_hi_full[15:0];
    end

    // stage 2: 48-bit phases, truncation to the turn fraction
    logic [47:0] ill48, beat48, path48, lp48, il48, se48;
    logic [31:0] p_snr_full, p_ill_full;

    assign ill48  = ill_lo_reg[47:0] + {ill_hi_reg, 32'd0};
    assign beat48 = beat_lo_reg[47:0] + {beat_hi_reg, 32'd0};
    assign path48 = path_lo_reg[47:0] + {path_hi_reg, 32'd0};
    assign lp48   = beat48 + path48;
    assign il48   = ill48 - path48;
    assign se48   = ill48 + beat48;

    assign p_snr_full = (cfg.low_pass ? lp48[47:16] : se48[47:16]) + cfg.snr_offset;
    assign p_ill_full = il48[47:16];

    logic                  v2_reg;
    logic [PHASE_BITS-1:0] snr_reg, ill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        snr_reg <= p_snr_full[31 -: PHASE_BITS];
        ill_reg <= p_ill_full[31 -: PHASE_BITS];
    end

    assign out_bus.valid = v2_reg;
    assign out_bus.p_snr = 32'(snr_reg) << PAD;
    assign out_bus.p_ill = 32'(ill_reg) << PAD;

endmodule

@@ src/tofmw_wave.sv @@
// ----------------------------------------------------------------------------
// tofmw_wave
// Wave stages: cosine table reads and fold terms, then per-type waveforms.
// ----------------------------------------------------------------------------
module tofmw_wave #(
    parameter int COS_TABLE_DEPTH = tofmw_pkg::DEF_COS_TABLE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tofmw_pkg::cfg_t       cfg,
    input  tofmw_pkg::phase_bus_t in_bus,
    output tofmw_pkg::wave_bus_t  out_bus
);
    import tofmw_pkg::*;

    localparam int IW = $clog2(COS_TABLE_DEPTH + 1);
    localparam int PW = 30 + IW;
    localparam longint Q30ONE      = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint K_DIV [1:10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};

    typedef logic [16:0] rom_t [0:COS_TABLE_DEPTH];

    // quarter-wave cosine, Q16, series evaluated in Q30
    function automatic rom_t build_rom();
        rom_t   rom;
        longint x, x2, term, sum, u, v;
        for (int i = 0; i <= COS_TABLE_DEPTH; i++)
        begin
            x    = HALF_PI_Q30 * longint'(i) / COS_TABLE_DEPTH;
            x2   = x * x / Q30ONE;
            term = Q30ONE;
            sum  = Q30ONE;
            for (int k = 1; k <= 10; k++)
            begin
                term = -(term * x2 / Q30ONE);
                term = term / K_DIV[k];
                sum  = sum + term;
            end
            u = sum + 64'sd8192;
            if (u >= 0)
                v = u / 16384;
            else
                v = -((-u + 64'sd16383) / 16384);
            if (v < 0)
                v = 0;
            rom[i] = 17'(v);
        end
        return rom;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    // table address of the nearest entry, mirrored in odd quadrants
    function automatic logic [IW-1:0] rom_addr(input logic [31:0] p);
        logic [PW-1:0] prod;
        logic [IW-1:0] idx;
        prod = PW'(p[29:0]) * PW'(COS_TABLE_DEPTH) + (PW'(1) << 29);
        idx  = prod[PW-1:30];
        return p[30] ? (IW'(COS_TABLE_DEPTH) - idx) : idx;
    endfunction

    // stage 3: table reads, folds, square for the cubic
    logic [31:0] fold_s, fold_i;
    logic [48:0] c2_full;

    assign fold_s  = fold(in_bus.p_snr);
    assign fold_i  = fold(in_bus.p_ill);
    assign c2_full = fold_s[31:7] * fold_s[31:7];

    logic        v3_reg;
    logic [16:0] rom_s_reg, rom_i_reg;
    logic        neg_s_reg, neg_i_reg, pos_s_reg, pos_i_reg;
    logic [31:0] fold_s_reg, fold_i_reg;
    logic [48:0] c2_reg;
    logic [24:0] c24_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= in_bus.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rom_s_reg  <= COS_ROM[rom_addr(in_bus.p_snr)];
        rom_i_reg  <= COS_ROM[rom_addr(in_bus.p_ill)];
        neg_s_reg  <= in_bus.p_snr[31] ^ in_bus.p_snr[30];
        neg_i_reg  <= in_bus.p_ill[31] ^ in_bus.p_ill[30];
        pos_s_reg  <= (in_bus.p_snr < 32'h4000_0000) || (in_bus.p_snr > 32'hC000_0000);
        pos_i_reg  <= (in_bus.p_ill < 32'h4000_0000) || (in_bus.p_ill > 32'hC000_0000);
        fold_s_reg <= fold_s;
        fold_i_reg <= fold_i;
        c2_reg     <= c2_full;
        c24_reg    <= fold_s[31:7];
    end

    // stage 4: signed cosine, linear waves, cube
    function automatic logic signed [17:0] lin_wave(input logic [31:0] f);
        logic signed [34:0] t;
        t = 35'sd2147483648 + 35'sd16384 - ($signed({3'b000, f}) <<< 1);
        return 18'(t >>> 15);
    endfunction

    function automatic logic signed [17:0] full_wave(input logic [2:0] code,
                                                     input logic pos,
                                                     input logic [31:0] f,
                                                     input logic signed [17:0] c);
        logic signed [17:0] w;
        unique case (code)
            WAVE_RECT: w = pos ? 18'sd65536 : -18'sd65536;
            WAVE_TRI:  w = lin_wave(f);
            default:   w = c;
        endcase
        return w;
    endfunction

    logic signed [17:0] cos_s, cos_i, lp_rect, lp_trap, lp_cos, lp_sel, se_val, il_val;
    logic signed [33:0] rect_t;
    logic signed [18:0] cos_lp_t;
    logic [48:0]        c3_full;

    assign cos_s    = neg_s_reg ? -$signed({1'b0, rom_s_reg}) : $signed({1'b0, rom_s_reg});
    assign cos_i    = neg_i_reg ? -$signed({1'b0, rom_i_reg}) : $signed({1'b0, rom_i_reg});
    assign rect_t   = 34'sd1073741824 + 34'sd16384 - $signed({2'b00, fold_s_reg});
    assign lp_rect  = 18'(rect_t >>> 15);
    assign cos_lp_t = {cos_s[17], cos_s} + 19'sd2;
    assign lp_cos   = 18'(cos_lp_t >>> 2);
    // full 49-bit cube, c^2 cut to Q24 times c
    assign c3_full  = c2_reg[48:24] * c24_reg;

    // trapezoid clamp at plus and minus one half
    always_comb
    begin
        lp_trap = lin_wave(fold_s_reg);
        if (lp_trap > 18'sd32768)
            lp_trap = 18'sd32768;
        else if (lp_trap < -18'sd32768)
            lp_trap = -18'sd32768;
    end

    always_comb
    begin
        unique case (cfg.snr_wave)
            WAVE_RECT: lp_sel = lp_rect;
            WAVE_TRAP: lp_sel = lp_trap;
            default:   lp_sel = lp_cos;
        endcase
    end

    assign se_val = full_wave(cfg.snr_wave, pos_s_reg, fold_s_reg, cos_s);
    assign il_val = full_wave(cfg.ill_wave, pos_i_reg, fold_i_reg, cos_i);

    logic               v4_reg;
    logic signed [18:0] ill_term_reg;
    logic signed [17:0] snr_term_reg, lp_val_reg;
    logic [48:0]        c2_out_reg, c3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ill_term_reg <= {il_val[17], il_val} + 19'sd65536;
        snr_term_reg <= se_val;
        lp_val_reg   <= lp_sel;
        c2_out_reg   <= c2_reg;
        c3_reg       <= c3_full;
    end

    assign out_bus.valid    = v4_reg;
    assign out_bus.ill_term = ill_term_reg;
    assign out_bus.snr_term = snr_term_reg;
    assign out_bus.lp_val   = lp_val_reg;
    assign out_bus.c2       = c2_out_reg;
    assign out_bus.c3       = c3_reg;

endmodule

@@ src/tofmw_mix.sv @@
// ----------------------------------------------------------------------------
// tofmw_mix
// Mix stages: cubic division by six, full product, rounding and selection.
// ----------------------------------------------------------------------------
module tofmw_mix (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tofmw_pkg::cfg_t      cfg,
    input  tofmw_pkg::wave_bus_t in_bus,
    output logic                 out_valid,
    output logic signed [17:0]   out_weight
);
    import tofmw_pkg::*;

    localparam logic [18:0] RECIP3 = 19'd349526;

    // stage 5: (4c^3 - 6c^2 + 1) / 6, floor by shift then reciprocal of three
    logic signed [52:0] num, u, w53;
    logic [18:0]        w;
    logic [37:0]        q;
    logic signed [18:0] tri_t;

    assign num   = ($signed({4'b0000, in_bus.c3}) <<< 2)
                 - $signed({4'b0000, in_bus.c2}) * 53'sd6 + (53'sd1 <<< 48);
    assign u     = num + (53'sd3 <<< 32);
    assign w53   = (u >>> 33) + 53'sd196608;
    assign w     = w53[18:0];
    assign q     = w * RECIP3;
    assign tri_t = $signed({1'b0, q[37:20]}) - 19'sd65536;

    logic               v5_reg;
    logic signed [36:0] prod_reg;
    logic signed [17:0] tri_reg, lp_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= in_bus.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= in_bus.ill_term * in_bus.snr_term;
        tri_reg    <= tri_t[17:0];
        lp_val_reg <= in_bus.lp_val;
    end

    // stage 6: round the product, pick the result
    logic signed [36:0] full_t;
    logic signed [17:0] weight_next;
    logic signed [17:0] weight_reg;
    logic               done_reg;

    assign full_t = (prod_reg + 37'sd65536) >>> 17;

    always_comb
    begin
        if (!cfg.low_pass)
            weight_next = full_t[17:0];
        else if (cfg.snr_wave == WAVE_TRI)
            weight_next = tri_reg;
        else
            weight_next = lp_val_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
    end

    assign out_valid  = done_reg;
    assign out_weight = weight_reg;

endmodule

@@ src/tof_modulation_weight.sv @@
// ----------------------------------------------------------------------------
// tof_modulation_weight
// Per-sample modulation weight of a time-of-flight Doppler camera.
// ----------------------------------------------------------------------------
// Usage:
//   A sample (sample_time, path_dist) is taken at a rising edge with start
//   high and busy low. busy stays low: a sample may be issued every cycle.
//   The weight appears on weight for one cycle with done high, in issue
//   order; the receiver cannot stall. Two phase stages (split 48-bit rate
//   products, then phase sums), two wave stages (registered cosine table
//   read, then the cubic term) and two mix stages (divide by six, product
//   and rounding) form the pipeline. Throughput is one sample per cycle.
//   Registers are written through wr_en / wr_index / wr_data; the user
//   must write them only while no sample is in flight; the block itself
//   does not enforce this. Indexes beyond the register list are ignored.
//   Reset clears the pipeline valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`include "tof_modulation_weight_defines.svh"

module tof_modulation_weight #(
    parameter int COS_TABLE_DEPTH = tofmw_pkg::DEF_COS_TABLE_DEPTH,
    parameter int PHASE_BITS      = tofmw_pkg::DEF_PHASE_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [31:0]                 sample_time,
    input  logic [31:0]                 path_dist,
    output logic                        done,
    output logic signed [17:0]          weight,
    input  logic                        wr_en,
    input  logic [2:0]                  wr_index,
    input  logic [tofmw_pkg::DATA_W-1:0] wr_data
);
    import tofmw_pkg::*;

    // configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.illum_rate <= 48'd8444249301;
            cfg_reg.beat_rate  <= 48'd187650;
            cfg_reg.path_rate  <= 48'd429496730;
            cfg_reg.snr_offset <= 32'd0;
            cfg_reg.snr_wave   <= WAVE_SINE;
            cfg_reg.ill_wave   <= WAVE_SINE;
            cfg_reg.low_pass   <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_ILLUM_RATE: cfg_reg.illum_rate <= wr_data[47:0];
                REG_BEAT_RATE:  cfg_reg.beat_rate  <= wr_data[47:0];
                REG_PATH_RATE:  cfg_reg.path_rate  <= wr_data[47:0];
                REG_SNR_OFFSET: cfg_reg.snr_offset <= wr_data[31:0];
                REG_SNR_WAVE:   cfg_reg.snr_wave   <= wr_data[2:0];
                REG_ILL_WAVE:   cfg_reg.ill_wave   <= wr_data[2:0];
                REG_LOW_PASS:   cfg_reg.low_pass   <= wr_data[0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    // pipeline
    phase_bus_t phase_bus;
    wave_bus_t  wave_bus;

    tofmw_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .sample_time (sample_time),
        .path_dist   (path_dist),
        .cfg         (cfg_reg),
        .out_bus     (phase_bus)
    );

    tofmw_wave #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_wave (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_bus  (phase_bus),
        .out_bus (wave_bus)
    );

    tofmw_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_bus     (wave_bus),
        .out_valid  (done),
        .out_weight (weight)
    );

    // checks
    `TOFMW_ASSERT_IMP(a_latency, start && !busy, ##6 done, "sample lost in the pipeline")
    `TOFMW_ASSERT_IMP(a_no_spurious, done, $past(start, 6), "result without a sample")
    `TOFMW_ASSERT_NXT(a_phase_valid, start && !busy, ##1 phase_bus.valid,
        "phase stage valid lost")
    `TOFMW_ASSERT_IMP(a_range, done, weight >= -18'sd65536 && weight <= 18'sd65536,
        "weight out of range")
    `TOFMW_ASSERT_IMP(a_lp_rect, done && cfg_reg.low_pass && cfg_reg.snr_wave == WAVE_RECT,
        weight >= -18'sd32768 && weight <= 18'sd32768, "low-pass rectangle beyond one half")

endmodule

@@ sim/tb_tof_modulation_weight.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tof_modulation_weight
// Self-checking bench for the modulation weight block. A directed table
// covers the waveform codes of both modes at zero phase and the input
// extremes; random samples then run under a series of register settings.
// Every weight is checked against a typed table value or a local fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_tof_modulation_weight;
    import tofmw_pkg::*;

    localparam int  TAB_DEPTH = 1024;
    localparam int  PH_BITS   = 32;
    localparam longint Q30    = 64'sd1073741824;
    localparam longint HPI_Q30 = 64'sd1686629713;
    localparam logic [2:0] REG_NONE = 3'd7;   // beyond the register list
    localparam int  N_PHASES  = 10;
    localparam int  PHASE_ITEMS = 200;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [31:0]        sample_time = '0;
    logic [31:0]        path_dist = '0;
    logic               done;
    logic signed [17:0] weight;
    logic               wr_en = 1'b0;
    logic [2:0]         wr_index = '0;
    logic [DATA_W-1:0]  wr_data = '0;

    // shadow of the register file
    logic [47:0] m_illum_rate, m_beat_rate, m_path_rate;
    logic [31:0] m_snr_offset;
    logic [2:0]  m_snr_wave, m_ill_wave;
    logic        m_low_pass;

    longint      cos_tab [0:TAB_DEPTH];
    logic [17:0] weights_due [$];
    int          errors = 0;

    typedef struct {
        logic        low_pass;
        logic [2:0]  snr_wave;
        logic [2:0]  ill_wave;
        logic [31:0] t;
        logic [31:0] len;
        bit          typed;
        logic [17:0] w;
    } row_t;

    row_t rows [16];

    tof_modulation_weight dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_time(sample_time), .path_dist(path_dist),
        .done(done), .weight(weight),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // nearest integer, ties toward plus infinity
    function automatic longint rnd_div(input longint num, input longint den);
        longint u;
        u = num + den / 2;
        if (u >= 0)
            return u / den;
        return -((-u + den - 1) / den);
    endfunction

    function automatic void build_cos_tab();
        longint x, x2, term, sum, v;
        for (int i = 0; i <= TAB_DEPTH; i++)
        begin
            x = HPI_Q30 * i / TAB_DEPTH;
            x2 = x * x / Q30;
            term = Q30;
            sum = Q30;
            for (int k = 1; k <= 10; k++)
            begin
                term = -(term * x2 / Q30);
                term = term / ((2 * k - 1) * (2 * k));
                sum += term;
            end
            v = rnd_div(sum, 16384);
            cos_tab[i] = (v < 0) ? 0 : v;
        end
    endfunction

    function automatic longint cos_q16(input logic [31:0] p);
        longint r, idx;
        r = p[29:0];
        idx = (r * TAB_DEPTH + (64'sd1 << 29)) >>> 30;
        if (idx > TAB_DEPTH)
            idx = TAB_DEPTH;
        case (p[31:30])
            2'd0: return cos_tab[idx];
            2'd1: return -cos_tab[TAB_DEPTH - idx];
            2'd2: return -cos_tab[idx];
            default: return cos_tab[TAB_DEPTH - idx];
        endcase
    endfunction

    // turn distance to nearest whole turn
    function automatic longint half_turn(input logic [31:0] p);
        logic [32:0] d;
        d = p[31] ? (33'h1_0000_0000 - p) : {1'b0, p};
        return d;
    endfunction

    function automatic logic [31:0] to_phase(input logic [47:0] ph,
                                             input logic [31:0] add);
        logic [31:0] p, low;
        p = ph[47:16] + add;
        low = 32'((33'd1 << (32 - PH_BITS)) - 1);
        return p & ~low;
    endfunction

    function automatic longint lp_wave(input logic [31:0] p, input logic [2:0] kind);
        longint c, c24, c2, c3, v;
        c = half_turn(p);
        case (kind)
            WAVE_RECT: return rnd_div((64'sd1 << 30) - c, 64'sd1 << 15);
            WAVE_TRI:
            begin
                c24 = c >>> 7;
                c2 = c24 * c24;
                c3 = (c2 >>> 24) * c24;
                return rnd_div(4 * c3 - 6 * c2 + (64'sd1 << 48), 64'sd6 << 32);
            end
            WAVE_TRAP:
            begin
                v = rnd_div((64'sd1 << 31) - 2 * c, 64'sd1 << 15);
                if (v > 32768) v = 32768;
                if (v < -32768) v = -32768;
                return v;
            end
            default: return rnd_div(cos_q16(p), 4);
        endcase
    endfunction

    function automatic longint full_wave(input logic [31:0] p, input logic [2:0] kind);
        case (kind)
            WAVE_RECT: return (p < 32'h4000_0000 || p > 32'hC000_0000) ? 65536 : -65536;
            WAVE_TRI: return rnd_div((64'sd1 << 31) - 2 * half_turn(p), 64'sd1 << 15);
            default: return cos_q16(p);
        endcase
    endfunction

    function automatic logic [17:0] predict_weight(input logic [31:0] t,
                                                   input logic [31:0] len);
        logic [95:0] path_prod, prod;
        logic [47:0] path_ph, ph;
        longint      il, se, w;
        path_prod = m_path_rate * len;
        path_ph = path_prod[47:0];
        if (m_low_pass)
        begin
            prod = m_beat_rate * t;
            ph = prod[47:0] + path_ph;
            w = lp_wave(to_phase(ph, m_snr_offset), m_snr_wave);
        end
        else
        begin
            prod = m_illum_rate * t;
            ph = prod[47:0] - path_ph;
            il = full_wave(to_phase(ph, 32'd0), m_ill_wave) + 65536;
            prod = ({1'b0, m_illum_rate} + {1'b0, m_beat_rate}) * t;
            se = full_wave(to_phase(prod[47:0], m_snr_offset), m_snr_wave);
            w = rnd_div(il * se, 131072);
        end
        return w[17:0];
    endfunction

    // one write per clock, wr_en stays high across a burst
    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        case (idx)
            REG_ILLUM_RATE: m_illum_rate = val;
            REG_BEAT_RATE:  m_beat_rate = val;
            REG_PATH_RATE:  m_path_rate = val;
            REG_SNR_OFFSET: m_snr_offset = val[31:0];
            REG_SNR_WAVE:   m_snr_wave = val[2:0];
            REG_ILL_WAVE:   m_ill_wave = val[2:0];
            REG_LOW_PASS:   m_low_pass = val[0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // drain the pipeline before touching registers
    task automatic quiesce();
        wait (weights_due.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [47:0] rand48();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [47:0] rand_rate();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1 << 20);
            1: return {16'd0, $urandom};
            default: return rand48();
        endcase
    endfunction

    function automatic logic [31:0] rand_input();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1000);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    // issue one sample; start stays high when there is no gap
    task automatic issue(input logic [31:0] t, input logic [31:0] len, input int gap,
                         input bit typed, input logic [17:0] w_typed);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        sample_time <= t;
        path_dist <= len;
        do
            @(posedge clk);
        while (busy);
        weights_due.push_back(typed ? w_typed : predict_weight(t, len));
    endtask

    // check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (weights_due.size() == 0)
            begin
                $display("%0t: weight %0d with none expected", $realtime, weight);
                errors++;
            end
            else
            begin
                logic [17:0] w_exp;
                w_exp = weights_due.pop_front();
                if (weight !== w_exp)
                begin
                    $display("%0t: weight expected %0d actual %0d", $realtime,
                             $signed(w_exp), weight);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int  gap_max;
        bit  burst;
        build_cos_tab();
        m_illum_rate = 48'd8444249301;
        m_beat_rate  = 48'd187650;
        m_path_rate  = 48'd429496730;
        m_snr_offset = '0;
        m_snr_wave   = WAVE_SINE;
        m_ill_wave   = WAVE_SINE;
        m_low_pass   = 1'b1;

        // zero phase rows give the waveform peak directly
        rows[0]  = '{1'b1, WAVE_SINE, WAVE_SINE, 32'd0, 32'd0, 1'b1, 18'd16384};
        rows[1]  = '{1'b1, WAVE_RECT, WAVE_SINE, 32'd0, 32'd0, 1'b1, 18'd32768};
        rows[2]  = '{1'b1, WAVE_TRI,  WAVE_SINE, 32'd0, 32'd0, 1'b1, 18'd10923};
        rows[3]  = '{1'b1, WAVE_TRAP, WAVE_SINE, 32'd0, 32'd0, 1'b1, 18'd32768};
        rows[4]  = '{1'b1, WAVE_SAW,  WAVE_SINE, 32'd0, 32'd0, 1'b1, 18'd16384};
        rows[5]  = '{1'b1, 3'd5,      WAVE_SINE, 32'd0, 32'd0, 1'b1, 18'd16384};
        rows[6]  = '{1'b1, WAVE_SINE, WAVE_SINE, '1, '1, 1'b0, '0};
        rows[7]  = '{1'b1, WAVE_TRI,  WAVE_SINE, '1, 32'd0, 1'b0, '0};
        rows[8]  = '{1'b1, WAVE_TRAP, WAVE_SINE, 32'd0, '1, 1'b0, '0};
        rows[9]  = '{1'b0, WAVE_SINE, WAVE_SINE, 32'd0, 32'd0, 1'b1, 18'd65536};
        rows[10] = '{1'b0, WAVE_RECT, WAVE_RECT, 32'd0, 32'd0, 1'b1, 18'd65536};
        rows[11] = '{1'b0, WAVE_TRI,  WAVE_TRI,  32'd0, 32'd0, 1'b1, 18'd65536};
        rows[12] = '{1'b0, WAVE_TRAP, WAVE_SAW,  32'd0, 32'd0, 1'b1, 18'd65536};
        rows[13] = '{1'b0, 3'd7,      3'd7,      32'd0, 32'd0, 1'b1, 18'd65536};
        rows[14] = '{1'b0, WAVE_RECT, WAVE_TRI,  '1, '1, 1'b0, '0};
        rows[15] = '{1'b0, WAVE_TRI,  WAVE_RECT, 32'h1234_5678, 32'hFFFF_0000, 1'b0, '0};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (rows[i])
        begin
            if (rows[i].low_pass !== m_low_pass || rows[i].snr_wave !== m_snr_wave ||
                rows[i].ill_wave !== m_ill_wave)
            begin
                start <= 1'b0;
                quiesce();
                write_reg(REG_SNR_WAVE, {45'd0, rows[i].snr_wave});
                write_reg(REG_ILL_WAVE, {45'd0, rows[i].ill_wave});
                write_reg(REG_LOW_PASS, {47'd0, rows[i].low_pass});
                end_writes();
            end
            issue(rows[i].t, rows[i].len, $urandom_range(0, 2), rows[i].typed, rows[i].w);
        end

        // random phases, the first two at the rate extremes
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            start <= 1'b0;
            quiesce();
            case (ph)
                0:
                begin
                    write_reg(REG_ILLUM_RATE, '0);
                    write_reg(REG_BEAT_RATE, '0);
                    write_reg(REG_PATH_RATE, '0);
                    write_reg(REG_SNR_OFFSET, '0);
                end
                1:
                begin
                    write_reg(REG_ILLUM_RATE, '1);
                    write_reg(REG_BEAT_RATE, '1);
                    write_reg(REG_PATH_RATE, '1);
                    write_reg(REG_SNR_OFFSET, '1);
                end
                default:
                begin
                    write_reg(REG_ILLUM_RATE, rand_rate());
                    write_reg(REG_BEAT_RATE, rand_rate());
                    write_reg(REG_PATH_RATE, rand_rate());
                    write_reg(REG_SNR_OFFSET, rand48());
                end
            endcase
            // upper data bits are junk on the narrow registers
            write_reg(REG_SNR_WAVE, rand48());
            write_reg(REG_ILL_WAVE, rand48());
            write_reg(REG_LOW_PASS, rand48());
            write_reg(REG_NONE, rand48());
            end_writes();

            burst = ($urandom_range(0, 2) == 0);
            gap_max = burst ? 0 : 13;
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue(rand_input(), rand_input(), $urandom_range(0, gap_max), 1'b0, '0);
        end
        start <= 1'b0;

        wait (weights_due.size() == 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
